// ===== hdl/kaph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kaph_pkg;

  // Field and register widths
  localparam int unsigned CodeW  = 16;
  localparam int unsigned EventW = 4;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned HoldW  = 5;
  localparam int unsigned PowerW = 12;

  // Polls a key must be held before the millisecond repeat timer runs
  localparam logic [HoldW-1:0] HOLD_POLLS = 5'd20;

  // Register reset values
  localparam logic [CfgW-1:0] ON_OFF_RESET   = 10'd100;
  localparam logic [CfgW-1:0] DELAY_RESET    = 10'd1000;
  localparam logic [CfgW-1:0] INTERVAL_RESET = 10'd100;

  // Power counter: reset is twice the on/off time; all ones is the armed state
  localparam logic signed [PowerW-1:0] POWER_RESET = 12'sd200;
  localparam logic signed [PowerW-1:0] POWER_ARMED = -12'sd1;

  // Item kinds
  localparam logic ACT_POLL = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Key event codes
  localparam logic [EventW-1:0] EV_NONE  = 4'd0;
  localparam logic [EventW-1:0] EV_POWER = 4'd1;

  // Expander codes of the keys, in event order after the power key
  localparam logic [CodeW-1:0] CODE_POWER = 16'd65287;
  localparam logic [CodeW-1:0] CODE_K2    = 16'd64519;
  localparam logic [CodeW-1:0] CODE_K3    = 16'd64007;
  localparam logic [CodeW-1:0] CODE_K4    = 16'd62983;
  localparam logic [CodeW-1:0] CODE_K5    = 16'd60935;
  localparam logic [CodeW-1:0] CODE_K6    = 16'd56839;
  localparam logic [CodeW-1:0] CODE_K7    = 16'd48647;
  localparam logic [CodeW-1:0] CODE_K8    = 16'd32263;
  localparam logic [CodeW-1:0] CODE_K9    = 16'd65030;
  localparam logic [CodeW-1:0] CODE_K10   = 16'd65029;
  localparam logic [CodeW-1:0] CODE_K11   = 16'd65027;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    CFG_ON_OFF_TIME     = 2'd0,
    CFG_REPEAT_DELAY    = 2'd1,
    CFG_REPEAT_INTERVAL = 2'd2
  } cfg_reg_t;

  // Input word
  typedef struct packed {
    logic             action;
    logic [CodeW-1:0] key_code;
    logic             power_pin;
    logic             mask_readback_zero;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [EventW-1:0] key_event;
    logic              power_off;
    logic              keypad_fault;
  } out_word_t;

  // Map an expander code to its key event; EV_NONE for an unknown code.
  function automatic logic [EventW-1:0] key_class(input logic [CodeW-1:0] code);
    logic [EventW-1:0] ev;
    case (code)
      CODE_POWER: ev = EV_POWER;
      CODE_K2:    ev = 4'd2;
      CODE_K3:    ev = 4'd3;
      CODE_K4:    ev = 4'd4;
      CODE_K5:    ev = 4'd5;
      CODE_K6:    ev = 4'd6;
      CODE_K7:    ev = 4'd7;
      CODE_K8:    ev = 4'd8;
      CODE_K9:    ev = 4'd9;
      CODE_K10:   ev = 4'd10;
      CODE_K11:   ev = 4'd11;
      default:    ev = EV_NONE;
    endcase
    return ev;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/keypad_autorepeat_power_hold.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  kaph_pkg::in_word_t (poll or tick)
// out_      output     out_valid/out_stall  kaph_pkg::out_word_t (one per item)
// cfg_      input      cfg_we               index cfg_index, data cfg_data
//
// The decode and counter update sit between the input port and the result
// register, so one word is accepted each cycle while in_stall is low.
// A result is held in the result register, or in the skid register on a stall.
// A skid register behind the result register keeps input flowing for one
// extra word while the result side stalls; in_stall rises only when both are full.
// Reset (rst_n low, synchronous) restores the register defaults and a power
// counter of 200.

module keypad_autorepeat_power_hold (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire kaph_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire                      out_stall,
  output kaph_pkg::out_word_t      out_word,
  input  wire                      cfg_we,
  input  wire [kaph_pkg::IdxW-1:0] cfg_index,
  input  wire [kaph_pkg::CfgW-1:0] cfg_data
);

  // Configuration registers
  logic [kaph_pkg::CfgW-1:0] on_off_r;
  logic [kaph_pkg::CfgW-1:0] delay_r;
  logic [kaph_pkg::CfgW-1:0] interval_r;

  // Key and power state
  logic                             latched_r, latched_nxt;
  logic [kaph_pkg::HoldW-1:0]       hold_r, hold_nxt;
  logic [kaph_pkg::CfgW-1:0]        rms_r, rms_nxt;
  logic signed [kaph_pkg::PowerW-1:0] pc_r, pc_nxt;

  // Output register and skid register
  logic                out_valid_r, skid_valid_r;
  kaph_pkg::out_word_t out_r, skid_r;
  kaph_pkg::out_word_t res;

  logic in_acc;
  logic out_take;

  // Combinational step temporaries
  logic [kaph_pkg::EventW-1:0]        cls;
  logic                               hit;
  logic signed [kaph_pkg::PowerW-1:0] oot_s;
  logic signed [kaph_pkg::PowerW-1:0] pc_a, pc_b, pc_dec;
  logic [kaph_pkg::CfgW:0]            rms_inc;
  logic [kaph_pkg::CfgW-1:0]          reload;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Decode the word and work out the next state and the result.
  always_comb begin
    cls     = kaph_pkg::key_class(in_word.key_code);
    hit     = (cls != kaph_pkg::EV_NONE);
    oot_s   = $signed({{(kaph_pkg::PowerW-kaph_pkg::CfgW){1'b0}}, on_off_r});
    rms_inc = {1'b0, rms_r} + {{kaph_pkg::CfgW{1'b0}}, 1'b1};
    reload  = (interval_r < delay_r) ? (delay_r - interval_r) : '0;

    latched_nxt = latched_r;
    hold_nxt    = hold_r;
    rms_nxt     = rms_r;
    pc_a        = pc_r;
    pc_b        = pc_r;
    pc_dec      = pc_r - 12'sd1;
    pc_nxt      = pc_r;
    res         = '0;

    if (in_word.action == kaph_pkg::ACT_TICK) begin
      // Millisecond tick: run the repeat timer once the hold is complete.
      if (hold_r == kaph_pkg::HOLD_POLLS) begin
        if (rms_inc >= {1'b0, delay_r}) begin
          rms_nxt     = reload;
          latched_nxt = 1'b0;
        end else begin
          rms_nxt = rms_inc[kaph_pkg::CfgW-1:0];
        end
      end else begin
        rms_nxt = '0;
      end
    end else begin
      res.keypad_fault = in_word.mask_readback_zero;

      // A new press emits its event; the power key may start the countdown.
      if (hit && !latched_r) begin
        res.key_event = cls;
        if (cls == kaph_pkg::EV_POWER && pc_r == kaph_pkg::POWER_ARMED
            && in_word.power_pin) begin
          pc_a = oot_s;
        end
      end

      // An unknown code drops the latch and the hold count.
      latched_nxt = hit;
      if (!hit) begin
        hold_nxt = '0;
      end else if (hold_r < kaph_pkg::HOLD_POLLS) begin
        hold_nxt = hold_r + 5'd1;
      end

      // Startup lockout counts down to the armed state.
      pc_b = pc_a;
      if (pc_a > oot_s) begin
        pc_dec = pc_a - 12'sd1;
        pc_b   = (pc_dec == oot_s) ? kaph_pkg::POWER_ARMED : pc_dec;
      end

      // Power-off countdown pulses when it reaches zero.
      pc_nxt = pc_b;
      if (pc_b > 12'sd0 && pc_b <= oot_s) begin
        pc_nxt        = pc_b - 12'sd1;
        res.power_off = (pc_b == 12'sd1);
      end
    end
  end

  // Configuration and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_off_r   <= kaph_pkg::ON_OFF_RESET;
      delay_r    <= kaph_pkg::DELAY_RESET;
      interval_r <= kaph_pkg::INTERVAL_RESET;
      latched_r  <= 1'b0;
      hold_r     <= '0;
      rms_r      <= '0;
      pc_r       <= kaph_pkg::POWER_RESET;
    end else begin
      if (in_acc) begin
        latched_r <= latched_nxt;
        hold_r    <= hold_nxt;
        rms_r     <= rms_nxt;
        pc_r      <= pc_nxt;
      end
      if (cfg_we) begin
        case (kaph_pkg::cfg_reg_t'(cfg_index))
          kaph_pkg::CFG_ON_OFF_TIME: begin
            on_off_r <= cfg_data;
            pc_r     <= $signed({{(kaph_pkg::PowerW-kaph_pkg::CfgW-1){1'b0}},
                                 cfg_data, 1'b0});
          end
          kaph_pkg::CFG_REPEAT_DELAY:    delay_r    <= cfg_data;
          kaph_pkg::CFG_REPEAT_INTERVAL: interval_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payloads
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kaph_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kaph_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_stall,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire kaph_pkg::out_word_t out_word
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result dropped or changed while stalled");

  // The input side stalls only when a result is already waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // An accepted word always leaves a result on offer in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result");

  // Key events stay within the defined codes.
  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.key_event <= 4'd11)
    else $error("key event code out of range");

  // The power-off pulse is never delivered in two results in a row.
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_word.power_off
      |=> !(out_valid && out_word.power_off))
    else $error("power-off pulse repeated");

endmodule

bind keypad_autorepeat_power_hold kaph_checker u_kaph_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

// ===== tb/sv/tb_keypad_autorepeat_power_hold.sv =====
`timescale 1ns / 1ps

module tb_keypad_autorepeat_power_hold;

  localparam int unsigned NumKeys    = 11;
  localparam int unsigned CycleLimit = 400000;

  // A code that matches no key releases the keypad.
  localparam logic [kaph_pkg::CodeW-1:0] NO_KEY  = 16'h0000;
  localparam logic [kaph_pkg::CodeW-1:0] ALL_ONE = 16'hFFFF;

  // Index past the last register; the block must ignore writes to it.
  localparam logic [kaph_pkg::IdxW-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kaph_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kaph_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [kaph_pkg::IdxW-1:0] cfg_index = '0;
  logic [kaph_pkg::CfgW-1:0] cfg_data = '0;

  // Shared test state
  bit idle_en = 1'b1;
  int unsigned fail_count = 0;
  int unsigned sent_items = 0;
  int unsigned cycle_count = 0;
  kaph_pkg::out_word_t due_reports[$];

  // Predicted copies of the registers and the keypad state
  logic [kaph_pkg::CfgW-1:0] on_off_reg = kaph_pkg::ON_OFF_RESET;
  logic [kaph_pkg::CfgW-1:0] delay_reg = kaph_pkg::DELAY_RESET;
  logic [kaph_pkg::CfgW-1:0] interval_reg = kaph_pkg::INTERVAL_RESET;
  logic latched = 1'b0;
  logic [kaph_pkg::HoldW-1:0] held_polls = '0;
  logic [kaph_pkg::CfgW-1:0] rpt_ms = '0;
  logic signed [kaph_pkg::PowerW-1:0] power_cnt = kaph_pkg::POWER_RESET;

  keypad_autorepeat_power_hold i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Expander code of each key event, power key first.
  function automatic logic [kaph_pkg::CodeW-1:0] code_of_key(input int unsigned ev);
    case (ev)
      1:       return kaph_pkg::CODE_POWER;
      2:       return kaph_pkg::CODE_K2;
      3:       return kaph_pkg::CODE_K3;
      4:       return kaph_pkg::CODE_K4;
      5:       return kaph_pkg::CODE_K5;
      6:       return kaph_pkg::CODE_K6;
      7:       return kaph_pkg::CODE_K7;
      8:       return kaph_pkg::CODE_K8;
      9:       return kaph_pkg::CODE_K9;
      10:      return kaph_pkg::CODE_K10;
      default: return kaph_pkg::CODE_K11;
    endcase
  endfunction

  // Advance the predicted keypad state by one word and return its result.
  function automatic kaph_pkg::out_word_t step_keypad(input kaph_pkg::in_word_t w);
    kaph_pkg::out_word_t r;
    int unsigned hit;
    int oot;
    logic [kaph_pkg::CfgW:0] next_ms;
    r = '0;
    if (w.action == kaph_pkg::ACT_TICK) begin
      // The repeat timer runs only while a key is fully held.
      if (held_polls == kaph_pkg::HOLD_POLLS) begin
        next_ms = {1'b0, rpt_ms} + 1'b1;
        if (next_ms >= {1'b0, delay_reg}) begin
          rpt_ms = (interval_reg < delay_reg) ? delay_reg - interval_reg : '0;
          latched = 1'b0;
        end else begin
          rpt_ms = next_ms[kaph_pkg::CfgW-1:0];
        end
      end else begin
        rpt_ms = '0;
      end
    end else begin
      r.keypad_fault = w.mask_readback_zero;
      oot = int'(on_off_reg);
      hit = 0;
      for (int unsigned k = 1; k <= NumKeys; k++) begin
        if (w.key_code == code_of_key(k)) begin
          hit = k;
        end
      end

      // Unknown code drops all hold state; a known one reports once per press.
      if (hit == 0) begin
        held_polls = '0;
        latched = 1'b0;
      end else if (!latched) begin
        latched = 1'b1;
        if (hit == 1) begin
          r.key_event = kaph_pkg::EV_POWER;
          if (power_cnt == kaph_pkg::POWER_ARMED && w.power_pin) begin
            power_cnt = kaph_pkg::PowerW'(oot);
          end
        end else begin
          r.key_event = kaph_pkg::EventW'(hit);
        end
      end
      if (latched && held_polls < kaph_pkg::HOLD_POLLS) begin
        held_polls++;
      end

      // Startup lockout counts down to armed, power-off countdown to zero.
      if (int'(power_cnt) > oot) begin
        power_cnt--;
        if (int'(power_cnt) == oot) begin
          power_cnt = kaph_pkg::POWER_ARMED;
        end
      end
      if (int'(power_cnt) > 0 && int'(power_cnt) <= oot) begin
        power_cnt--;
        if (power_cnt == 0) begin
          r.power_off = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Offer one word, sometimes after idling first, and predict it once taken.
  task automatic send_word(input kaph_pkg::in_word_t w);
    if (idle_en && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_reports.push_back(step_keypad(w));
    sent_items++;
  endtask

  task automatic send_poll(input logic [kaph_pkg::CodeW-1:0] code, input logic pin,
                           input logic fault);
    kaph_pkg::in_word_t w;
    w.action = kaph_pkg::ACT_POLL;
    w.key_code = code;
    w.power_pin = pin;
    w.mask_readback_zero = fault;
    send_word(w);
  endtask

  // Tick words carry random values in the fields that the block ignores.
  task automatic send_tick();
    kaph_pkg::in_word_t w;
    w = kaph_pkg::in_word_t'($urandom);
    w.action = kaph_pkg::ACT_TICK;
    send_word(w);
  endtask

  task automatic hold_key(input logic [kaph_pkg::CodeW-1:0] code, input int n);
    repeat (n) send_poll(code, 1'($urandom_range(1)), 1'b0);
  endtask

  // Lower valid and wait until every predicted result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Registers change only while the block is drained.
  task automatic write_reg(input logic [kaph_pkg::IdxW-1:0] idx,
                           input logic [kaph_pkg::CfgW-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      kaph_pkg::CFG_ON_OFF_TIME: begin
        on_off_reg = val;
        power_cnt = kaph_pkg::PowerW'(2 * int'(val));
      end
      kaph_pkg::CFG_REPEAT_DELAY:    delay_reg = val;
      kaph_pkg::CFG_REPEAT_INTERVAL: interval_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Every key once, each followed by a release, with the field extremes.
  task automatic test_key_decode();
    for (int unsigned k = 1; k <= NumKeys; k++) begin
      send_poll(code_of_key(k), k[0], k[1]);
      send_poll((k % 2 == 0) ? NO_KEY : ALL_ONE, k[1], k[0]);
    end
    send_tick();
    wait_idle();
  endtask

  // Lockout, arming, power key with the pin low and high, and the off pulse.
  task automatic test_power_hold();
    // A zero on/off time leaves the counter idle; the power key does nothing.
    write_reg(kaph_pkg::CFG_ON_OFF_TIME, 10'd0);
    send_poll(NO_KEY, 1'b1, 1'b0);
    send_poll(kaph_pkg::CODE_POWER, 1'b1, 1'b0);
    send_poll(NO_KEY, 1'b0, 1'b0);
    // Power key during the lockout still reports but leaves the counter alone.
    write_reg(kaph_pkg::CFG_ON_OFF_TIME, 10'd2);
    send_poll(kaph_pkg::CODE_POWER, 1'b1, 1'b0);
    send_poll(NO_KEY, 1'b0, 1'b0);
    send_poll(NO_KEY, 1'b0, 1'b0);
    // Armed now: pin low does not start the countdown, pin high does.
    send_poll(kaph_pkg::CODE_POWER, 1'b0, 1'b0);
    send_poll(NO_KEY, 1'b0, 1'b0);
    send_poll(kaph_pkg::CODE_POWER, 1'b1, 1'b1);
    send_poll(kaph_pkg::CODE_POWER, 1'b1, 1'b0);
    send_poll(NO_KEY, 1'b0, 1'b0);
    send_poll(kaph_pkg::CODE_POWER, 1'b1, 1'b0);
    // Largest on/off time and a write to the unused index.
    write_reg(kaph_pkg::CFG_ON_OFF_TIME, 10'd1023);
    write_reg(CFG_SPARE, 10'd1);
    send_poll(kaph_pkg::CODE_POWER, 1'b1, 1'b0);
    send_poll(NO_KEY, 1'b1, 1'b0);
    wait_idle();
  endtask

  // Auto-repeat: normal reload, saturated reload, tiny delays, a long delay.
  task automatic test_auto_repeat();
    write_reg(kaph_pkg::CFG_ON_OFF_TIME, 10'd1);
    write_reg(kaph_pkg::CFG_REPEAT_DELAY, 10'd4);
    write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, 10'd2);
    hold_key(kaph_pkg::CODE_K5, 21);
    repeat (10) begin
      send_tick();
      send_poll(kaph_pkg::CODE_K5, 1'b0, 1'b0);
    end
    // A release in the middle of the count clears the timer.
    send_tick();
    send_poll(NO_KEY, 1'b0, 1'b0);
    send_tick();

    // Interval not below the delay makes the reload saturate at zero.
    write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, 10'd1023);
    hold_key(kaph_pkg::CODE_K11, 20);
    repeat (6) begin
      send_tick();
      send_poll(kaph_pkg::CODE_K11, 1'b1, 1'b0);
    end
    send_poll(NO_KEY, 1'b0, 1'b0);

    // Zero and one millisecond delays.
    write_reg(kaph_pkg::CFG_REPEAT_DELAY, 10'd0);
    hold_key(kaph_pkg::CODE_POWER, 20);
    repeat (3) begin
      send_tick();
      send_poll(kaph_pkg::CODE_POWER, 1'b1, 1'b0);
    end
    write_reg(kaph_pkg::CFG_REPEAT_DELAY, 10'd1);
    repeat (3) begin
      send_tick();
      send_poll(kaph_pkg::CODE_POWER, 1'b0, 1'b0);
    end
    send_poll(NO_KEY, 1'b0, 1'b0);

    // Longer delay: the count climbs to the delay and reloads one tick below it.
    write_reg(kaph_pkg::CFG_REPEAT_DELAY, 10'd60);
    write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, 10'd1);
    hold_key(kaph_pkg::CODE_K8, 20);
    repeat (65) send_tick();
    send_poll(kaph_pkg::CODE_K8, 1'b0, 1'b0);
    send_poll(NO_KEY, 1'b0, 1'b0);
    wait_idle();
  endtask

  // One press of a random key: held polls, then ticks mixed with polls.
  task automatic random_hold();
    logic [kaph_pkg::CodeW-1:0] code;
    int n_mix;
    code = code_of_key($urandom_range(1, NumKeys));
    n_mix = $urandom_range(0, 30);
    repeat ($urandom_range(1, 24)) begin
      send_poll(code, 1'($urandom_range(1)), $urandom_range(99) < 8);
    end
    repeat (n_mix) begin
      if ($urandom_range(99) < 65) begin
        send_tick();
      end else begin
        send_poll(code, 1'($urandom_range(1)), $urandom_range(99) < 8);
      end
    end
    if ($urandom_range(3) == 0) begin
      send_poll(kaph_pkg::CodeW'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end else begin
      send_poll(NO_KEY, 1'($urandom_range(1)), 1'b0);
    end
  endtask

  // Random traffic over several register settings, one with no idling.
  task automatic test_random_traffic();
    int unsigned stop_at;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(kaph_pkg::CFG_ON_OFF_TIME, kaph_pkg::ON_OFF_RESET);
          write_reg(kaph_pkg::CFG_REPEAT_DELAY, kaph_pkg::DELAY_RESET);
          write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, kaph_pkg::INTERVAL_RESET);
        end
        1: begin
          write_reg(kaph_pkg::CFG_ON_OFF_TIME, 10'd3);
          write_reg(kaph_pkg::CFG_REPEAT_DELAY, 10'd5);
          write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, 10'd2);
        end
        2: begin
          write_reg(kaph_pkg::CFG_ON_OFF_TIME, 10'd1);
          write_reg(kaph_pkg::CFG_REPEAT_DELAY, 10'd2);
          write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, 10'd1);
        end
        3: begin
          write_reg(kaph_pkg::CFG_ON_OFF_TIME, kaph_pkg::CfgW'($urandom_range(1, 8)));
          write_reg(kaph_pkg::CFG_REPEAT_DELAY, kaph_pkg::CfgW'($urandom_range(2, 12)));
          write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, kaph_pkg::CfgW'($urandom_range(1, 15)));
        end
        4: begin
          write_reg(kaph_pkg::CFG_ON_OFF_TIME, 10'd1023);
          write_reg(kaph_pkg::CFG_REPEAT_DELAY, 10'd1023);
          write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, 10'd1000);
        end
        default: begin
          write_reg(kaph_pkg::CFG_ON_OFF_TIME, 10'd0);
          write_reg(kaph_pkg::CFG_REPEAT_DELAY, kaph_pkg::CfgW'($urandom_range(2, 9)));
          write_reg(kaph_pkg::CFG_REPEAT_INTERVAL, kaph_pkg::CfgW'($urandom_range(1, 9)));
        end
      endcase
      idle_en = (ph != 2);
      stop_at = sent_items + 50;
      while (sent_items < stop_at) begin
        if ($urandom_range(99) < 75) begin
          random_hold();
        end else begin
          send_word(kaph_pkg::in_word_t'($urandom));
        end
      end
      wait_idle();
    end
    idle_en = 1'b1;
  endtask

  // Result side: random stalls, and each accepted word checked in order.
  always @(posedge clk) begin : check_results
    kaph_pkg::out_word_t exp_r;
    out_stall <= idle_en && ($urandom_range(99) < 12);
    if (rst_n && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        fail_count++;
        $error("result word arrived with none expected");
      end else begin
        exp_r = due_reports.pop_front();
        if (out_word.key_event !== exp_r.key_event) begin
          fail_count++;
          $error("key_event: expected %0d, got %0d", exp_r.key_event, out_word.key_event);
        end
        if (out_word.power_off !== exp_r.power_off) begin
          fail_count++;
          $error("power_off: expected %0d, got %0d", exp_r.power_off, out_word.power_off);
        end
        if (out_word.keypad_fault !== exp_r.keypad_fault) begin
          fail_count++;
          $error("keypad_fault: expected %0d, got %0d", exp_r.keypad_fault,
                 out_word.keypad_fault);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_key_decode();
    test_power_hold();
    test_auto_repeat();
    test_random_traffic();
    wait_idle();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
